FILE: design/owm_pkg.sv
// owm_pkg: shared types, phase and script codes, command scripts and
// register map for the one-wire master. No dependencies.
`timescale 1ns / 1ps

package owm_pkg;

    localparam int PHASE_W = 4;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_IDLE     = 4'd0;
    localparam phase_t PH_RST_LOW  = 4'd1;
    localparam phase_t PH_RST_POLL = 4'd2;
    localparam phase_t PH_RST_WAIT = 4'd3;
    localparam phase_t PH_SETTLE   = 4'd4;
    localparam phase_t PH_WR_LOW   = 4'd5;
    localparam phase_t PH_WR_DATA  = 4'd6;
    localparam phase_t PH_RD_LOW   = 4'd7;
    localparam phase_t PH_RD_WAIT  = 4'd8;
    localparam phase_t PH_RD_REC   = 4'd9;

    typedef logic [2:0] act_t;
    localparam act_t ACT_END     = 3'd0;
    localparam act_t ACT_RST     = 3'd1;
    localparam act_t ACT_SETTLE  = 3'd2;
    localparam act_t ACT_WR      = 3'd3;
    localparam act_t ACT_RD      = 3'd4;
    localparam act_t ACT_WR_DATA = 3'd5;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_RESET = 3'd0;
    localparam cmd_t CMD_WRITE = 3'd1;
    localparam cmd_t CMD_READ  = 3'd2;
    localparam cmd_t CMD_SKIP  = 3'd3;
    localparam cmd_t CMD_TEMP  = 3'd4;

    localparam logic [7:0] SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CONVERT_T = 8'h44;
    localparam logic [7:0] READ_PAD  = 8'hBE;

    localparam logic [3:0] STEP_LOW_BYTE = 4'd8;

    typedef logic [2:0] cfg_addr_t;
    localparam cfg_addr_t CFG_RESET_LOW    = 3'd0;
    localparam cfg_addr_t CFG_POLL_US      = 3'd1;
    localparam cfg_addr_t CFG_POLLS        = 3'd2;
    localparam cfg_addr_t CFG_WRITE_LOW    = 3'd3;
    localparam cfg_addr_t CFG_WRITE_SLOT   = 3'd4;
    localparam cfg_addr_t CFG_READ_LOW     = 3'd5;
    localparam cfg_addr_t CFG_READ_SAMPLE  = 3'd6;
    localparam cfg_addr_t CFG_READ_RECOVER = 3'd7;

    typedef struct packed {
        logic [15:0] reset_low_us;
        logic [15:0] presence_poll_us;
        logic [3:0]  presence_polls;
        logic [7:0]  write_low_us;
        logic [7:0]  write_slot_us;
        logic [7:0]  read_low_us;
        logic [7:0]  read_sample_us;
        logic [7:0]  read_recover_us;
    } cfg_t;

    typedef struct packed {
        logic               line_level;
        logic [7:0]         data_byte;
        cmd_t               command;
        logic               start_req;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] temperature_raw;
        logic [7:0]         read_value;
        logic               presence_fail;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } result_t;

    function automatic act_t script_act(input cmd_t cmd, input logic [3:0] step);
        act_t a;
        a = ACT_END;
        case (cmd)
            CMD_RESET: if (step == 4'd0) a = ACT_RST;
            CMD_WRITE: if (step == 4'd0) a = ACT_WR_DATA;
            CMD_READ:  if (step == 4'd0) a = ACT_RD;
            CMD_SKIP: begin
                case (step)
                    4'd0:    a = ACT_RST;
                    4'd1:    a = ACT_SETTLE;
                    4'd2:    a = ACT_WR;
                    4'd3:    a = ACT_WR_DATA;
                    default: a = ACT_END;
                endcase
            end
            CMD_TEMP: begin
                case (step)
                    4'd0, 4'd4:       a = ACT_RST;
                    4'd1, 4'd5:       a = ACT_SETTLE;
                    4'd2, 4'd3, 4'd6, 4'd7: a = ACT_WR;
                    4'd8, 4'd9:       a = ACT_RD;
                    default:          a = ACT_END;
                endcase
            end
            default: a = ACT_END;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] script_byte(input cmd_t cmd, input logic [3:0] step);
        logic [7:0] b;
        b = 8'h00;
        if (cmd == CMD_SKIP && step == 4'd2) begin
            b = SKIP_ROM;
        end else if (cmd == CMD_TEMP) begin
            case (step)
                4'd2, 4'd6: b = SKIP_ROM;
                4'd3:       b = CONVERT_T;
                4'd7:       b = READ_PAD;
                default:    b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

FILE: design/one_wire_temp_sensor_master.sv
// one_wire_temp_sensor_master: one-wire bus master with temperature read script.
// Result word registered in the cycle after acceptance; 1 word per cycle while m_tready
// is high, set by the single sequencer step between handshake and result register.
// Result register frees for a new word in the cycle it is taken.
// Reset (aresetn low, synchronous) idles the sequencer, clears results and
// restores the register defaults. Depends on owm_pkg and owm_core.
`timescale 1ns / 1ps

module one_wire_temp_sensor_master #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_req[0], command[3:1], data_byte[11:4], line_level[12], zero[15:13]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive_low[0], busy_res[1], done_res[2], presence_fail[3], read_value[11:4],
    // temperature_raw[27:12], zero[31:28]
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    owm_pkg::cfg_t    cfg_reg;
    owm_pkg::tick_t   tick;
    owm_pkg::result_t result;
    logic             accept;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tick     = s_tdata[12:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    owm_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(accept),
        .tick   (tick),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us     <= 16'd480;
            cfg_reg.presence_poll_us <= 16'd1000;
            cfg_reg.presence_polls   <= 4'd5;
            cfg_reg.write_low_us     <= 8'd15;
            cfg_reg.write_slot_us    <= 8'd60;
            cfg_reg.read_low_us      <= 8'd1;
            cfg_reg.read_sample_us   <= 8'd10;
            cfg_reg.read_recover_us  <= 8'd50;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                owm_pkg::CFG_RESET_LOW:    cfg_reg.reset_low_us     <= cfg_wdata;
                owm_pkg::CFG_POLL_US:      cfg_reg.presence_poll_us <= cfg_wdata;
                owm_pkg::CFG_POLLS:        cfg_reg.presence_polls   <= cfg_wdata[3:0];
                owm_pkg::CFG_WRITE_LOW:    cfg_reg.write_low_us     <= cfg_wdata[7:0];
                owm_pkg::CFG_WRITE_SLOT:   cfg_reg.write_slot_us    <= cfg_wdata[7:0];
                owm_pkg::CFG_READ_LOW:     cfg_reg.read_low_us      <= cfg_wdata[7:0];
                owm_pkg::CFG_READ_SAMPLE:  cfg_reg.read_sample_us   <= cfg_wdata[7:0];
                owm_pkg::CFG_READ_RECOVER: cfg_reg.read_recover_us  <= cfg_wdata[7:0];
                default:                   cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {4'b0000, result};
        end
    end

endmodule

FILE: design/owm_core.sv
// owm_core: one-wire bus sequencer; advances by one microsecond tick per enable.
// Holds the script state, slot timer and results. Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  owm_pkg::tick_t   tick,
    input  owm_pkg::cfg_t    cfg,
    output owm_pkg::result_t result
);

    localparam logic [31:0] TMAX = (32'd1 << TIMER_BITS) - 32'd1;

    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [15:0] v);
        return (32'(v) > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(v);
    endfunction

    owm_pkg::phase_t         phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [2:0]              bit_index_reg, bit_index_next;
    logic [3:0]              poll_count_reg, poll_count_next;
    logic [3:0]              seq_step_reg, seq_step_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              temp_low_reg, temp_low_next;
    logic                    fail_reg, fail_next;
    owm_pkg::cmd_t           cmd_reg, cmd_next;
    logic [7:0]              data_reg, data_next;
    logic [7:0]              read_reg, read_next;
    logic [15:0]             temp_reg, temp_next;

    always_comb begin
        logic        slot_end;
        logic        do_begin;
        logic        done;
        logic        drive;
        owm_pkg::act_t act;

        phase_next      = phase_reg;
        timer_next      = timer_reg;
        bit_index_next  = bit_index_reg;
        poll_count_next = poll_count_reg;
        seq_step_next   = seq_step_reg;
        shift_next      = shift_reg;
        temp_low_next   = temp_low_reg;
        fail_next       = fail_reg;
        cmd_next        = cmd_reg;
        data_next       = data_reg;
        read_next       = read_reg;
        temp_next       = temp_reg;
        do_begin        = 1'b0;
        done            = 1'b0;
        drive           = 1'b0;

        slot_end = (timer_reg <= TIMER_BITS'(1));
        if (phase_reg != owm_pkg::PH_IDLE && phase_reg != owm_pkg::PH_RST_POLL) begin
            timer_next = slot_end ? '0 : timer_reg - TIMER_BITS'(1);
        end

        unique case (phase_reg)
            owm_pkg::PH_IDLE: begin
                if (tick.start_req && tick.command <= owm_pkg::CMD_TEMP) begin
                    cmd_next      = tick.command;
                    data_next     = tick.data_byte;
                    seq_step_next = 4'd0;
                    do_begin      = 1'b1;
                end
            end
            owm_pkg::PH_RST_LOW: begin
                drive = 1'b1;
                if (slot_end) phase_next = owm_pkg::PH_RST_POLL;
            end
            owm_pkg::PH_RST_POLL: begin
                if (!tick.line_level) begin
                    fail_next     = 1'b0;
                    seq_step_next = seq_step_reg + 4'd1;
                    do_begin      = 1'b1;
                end else begin
                    phase_next = owm_pkg::PH_RST_WAIT;
                    timer_next = sat_load(cfg.presence_poll_us);
                end
            end
            owm_pkg::PH_RST_WAIT: begin
                if (slot_end) begin
                    if (poll_count_reg >= cfg.presence_polls) begin
                        fail_next     = 1'b1;
                        seq_step_next = seq_step_reg + 4'd1;
                        do_begin      = 1'b1;
                    end else begin
                        poll_count_next = poll_count_reg + 4'd1;
                        phase_next      = owm_pkg::PH_RST_POLL;
                    end
                end
            end
            owm_pkg::PH_SETTLE: begin
                if (slot_end) begin
                    seq_step_next = seq_step_reg + 4'd1;
                    do_begin      = 1'b1;
                end
            end
            owm_pkg::PH_WR_LOW: begin
                drive = 1'b1;
                if (slot_end) begin
                    phase_next = owm_pkg::PH_WR_DATA;
                    timer_next = sat_load({8'h00, cfg.write_slot_us});
                end
            end
            owm_pkg::PH_WR_DATA: begin
                drive = ~shift_reg[0];
                if (slot_end) begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_index_reg == 3'd7) begin
                        seq_step_next = seq_step_reg + 4'd1;
                        do_begin      = 1'b1;
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = owm_pkg::PH_WR_LOW;
                        timer_next     = sat_load({8'h00, cfg.write_low_us});
                    end
                end
            end
            owm_pkg::PH_RD_LOW: begin
                drive = 1'b1;
                if (slot_end) begin
                    phase_next = owm_pkg::PH_RD_WAIT;
                    timer_next = sat_load({8'h00, cfg.read_sample_us});
                end
            end
            owm_pkg::PH_RD_WAIT: begin
                if (slot_end) begin
                    shift_next = {tick.line_level, shift_reg[7:1]};
                    phase_next = owm_pkg::PH_RD_REC;
                    timer_next = sat_load({8'h00, cfg.read_recover_us});
                end
            end
            owm_pkg::PH_RD_REC: begin
                if (slot_end) begin
                    if (bit_index_reg == 3'd7) begin
                        if (cmd_reg == owm_pkg::CMD_TEMP
                            && seq_step_reg == owm_pkg::STEP_LOW_BYTE) begin
                            temp_low_next = shift_reg;
                        end
                        seq_step_next = seq_step_reg + 4'd1;
                        do_begin      = 1'b1;
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        phase_next     = owm_pkg::PH_RD_LOW;
                        timer_next     = sat_load({8'h00, cfg.read_low_us});
                    end
                end
            end
            default: begin
                phase_next = owm_pkg::PH_IDLE;
            end
        endcase

        // start the next script action
        act = do_begin ? owm_pkg::script_act(cmd_next, seq_step_next) : owm_pkg::ACT_END;
        if (do_begin) begin
            unique case (act)
                owm_pkg::ACT_RST: begin
                    poll_count_next = 4'd0;
                    phase_next      = owm_pkg::PH_RST_LOW;
                    timer_next      = sat_load(cfg.reset_low_us);
                end
                owm_pkg::ACT_SETTLE: begin
                    phase_next = owm_pkg::PH_SETTLE;
                    timer_next = sat_load(cfg.presence_poll_us);
                end
                owm_pkg::ACT_WR, owm_pkg::ACT_WR_DATA: begin
                    shift_next     = (act == owm_pkg::ACT_WR)
                                   ? owm_pkg::script_byte(cmd_next, seq_step_next)
                                   : data_next;
                    bit_index_next = 3'd0;
                    phase_next     = owm_pkg::PH_WR_LOW;
                    timer_next     = sat_load({8'h00, cfg.write_low_us});
                end
                owm_pkg::ACT_RD: begin
                    shift_next     = 8'h00;
                    bit_index_next = 3'd0;
                    phase_next     = owm_pkg::PH_RD_LOW;
                    timer_next     = sat_load({8'h00, cfg.read_low_us});
                end
                default: begin
                    if (cmd_next == owm_pkg::CMD_READ) read_next = shift_next;
                    if (cmd_next == owm_pkg::CMD_TEMP) temp_next = {shift_next, temp_low_next};
                    phase_next    = owm_pkg::PH_IDLE;
                    timer_next    = '0;
                    seq_step_next = 4'd0;
                    done          = 1'b1;
                end
            endcase
        end

        result.drive_low       = drive;
        result.busy_res        = (phase_next != owm_pkg::PH_IDLE);
        result.done_res        = done;
        result.presence_fail   = fail_next;
        result.read_value      = read_next;
        result.temperature_raw = temp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= owm_pkg::PH_IDLE;
            timer_reg      <= '0;
            bit_index_reg  <= 3'd0;
            poll_count_reg <= 4'd0;
            seq_step_reg   <= 4'd0;
            shift_reg      <= 8'h00;
            temp_low_reg   <= 8'h00;
            fail_reg       <= 1'b0;
            cmd_reg        <= owm_pkg::CMD_RESET;
            data_reg       <= 8'h00;
            read_reg       <= 8'h00;
            temp_reg       <= 16'h0000;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            bit_index_reg  <= bit_index_next;
            poll_count_reg <= poll_count_next;
            seq_step_reg   <= seq_step_next;
            shift_reg      <= shift_next;
            temp_low_reg   <= temp_low_next;
            fail_reg       <= fail_next;
            cmd_reg        <= cmd_next;
            data_reg       <= data_next;
            read_reg       <= read_next;
            temp_reg       <= temp_next;
        end
    end

endmodule

FILE: tb/sv/owm_checker.sv
// owm_checker: watches the tick and result streams of the one-wire master,
// keeps its own copy of the sequencer and register file, and compares every result word.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_checker
    import owm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  cfg_addr_t   cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          errors,
    output int          outstanding,
    output int          cmds_finished,
    output logic        seq_busy
);

    typedef enum logic [2:0] {
        DO_END,
        DO_RESET,
        DO_SETTLE,
        DO_WRITE_FIXED,
        DO_WRITE_DATA,
        DO_READ
    } bus_action_e;

    cfg_t        regs;
    phase_t      ph;
    logic [15:0] slot_left;
    logic [2:0]  bit_pos;
    logic [3:0]  polls_seen;
    logic [3:0]  step;
    logic [7:0]  shifter;
    logic [7:0]  temp_lo;
    logic        no_presence;
    cmd_t        cmd_q;
    logic [7:0]  data_q;
    logic [7:0]  last_read;
    logic [15:0] last_temp;
    logic        cmd_done;
    int          word_no;
    result_t     due_words[$];

    assign seq_busy = (ph != PH_IDLE);

    function automatic bus_action_e action_at(input cmd_t c, input logic [3:0] s);
        bus_action_e a;
        a = DO_END;
        case (c)
            CMD_RESET: if (s == 4'd0) a = DO_RESET;
            CMD_WRITE: if (s == 4'd0) a = DO_WRITE_DATA;
            CMD_READ:  if (s == 4'd0) a = DO_READ;
            CMD_SKIP: begin
                if (s == 4'd0) a = DO_RESET;
                else if (s == 4'd1) a = DO_SETTLE;
                else if (s == 4'd2) a = DO_WRITE_FIXED;
                else if (s == 4'd3) a = DO_WRITE_DATA;
            end
            CMD_TEMP: begin
                if (s == 4'd0 || s == 4'd4) a = DO_RESET;
                else if (s == 4'd1 || s == 4'd5) a = DO_SETTLE;
                else if (s >= 4'd2 && s <= 4'd7 && s != 4'd4 && s != 4'd5) a = DO_WRITE_FIXED;
                else if (s == 4'd8 || s == 4'd9) a = DO_READ;
            end
            default: a = DO_END;
        endcase
        return a;
    endfunction

    // last tick of the running slot; zero and one both mean a single tick
    function automatic logic slot_end();
        if (slot_left <= 16'd1) begin
            slot_left = 16'd0;
            return 1'b1;
        end
        slot_left = slot_left - 16'd1;
        return 1'b0;
    endfunction

    task automatic start_action();
        bus_action_e a;
        a = action_at(cmd_q, step);
        case (a)
            DO_RESET: begin
                polls_seen = 4'd0;
                ph = PH_RST_LOW;
                slot_left = regs.reset_low_us;
            end
            DO_SETTLE: begin
                ph = PH_SETTLE;
                slot_left = regs.presence_poll_us;
            end
            DO_WRITE_FIXED, DO_WRITE_DATA: begin
                if (a == DO_WRITE_DATA) shifter = data_q;
                else if (step == 4'd3) shifter = CONVERT_T;
                else if (step == 4'd7) shifter = READ_PAD;
                else shifter = SKIP_ROM;
                bit_pos = 3'd0;
                ph = PH_WR_LOW;
                slot_left = {8'h00, regs.write_low_us};
            end
            DO_READ: begin
                shifter = 8'h00;
                bit_pos = 3'd0;
                ph = PH_RD_LOW;
                slot_left = {8'h00, regs.read_low_us};
            end
            default: begin
                if (cmd_q == CMD_READ) last_read = shifter;
                if (cmd_q == CMD_TEMP) last_temp = {shifter, temp_lo};
                ph = PH_IDLE;
                slot_left = 16'd0;
                step = 4'd0;
                cmd_done = 1'b1;
            end
        endcase
    endtask

    task automatic next_action();
        step = step + 4'd1;
        start_action();
    endtask

    task automatic advance_one_tick(input tick_t t, output result_t r);
        logic drive;
        drive = 1'b0;
        cmd_done = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (t.start_req && t.command <= CMD_TEMP) begin
                    cmd_q = t.command;
                    data_q = t.data_byte;
                    step = 4'd0;
                    start_action();
                end
            end
            PH_RST_LOW: begin
                drive = 1'b1;
                if (slot_end()) ph = PH_RST_POLL;
            end
            PH_RST_POLL: begin
                if (!t.line_level) begin
                    no_presence = 1'b0;
                    next_action();
                end else begin
                    ph = PH_RST_WAIT;
                    slot_left = regs.presence_poll_us;
                end
            end
            PH_RST_WAIT: begin
                if (slot_end()) begin
                    if (polls_seen >= regs.presence_polls) begin
                        no_presence = 1'b1;
                        next_action();
                    end else begin
                        polls_seen = polls_seen + 4'd1;
                        ph = PH_RST_POLL;
                    end
                end
            end
            PH_SETTLE: begin
                if (slot_end()) next_action();
            end
            PH_WR_LOW: begin
                drive = 1'b1;
                if (slot_end()) begin
                    ph = PH_WR_DATA;
                    slot_left = {8'h00, regs.write_slot_us};
                end
            end
            PH_WR_DATA: begin
                drive = ~shifter[0];
                if (slot_end()) begin
                    shifter = shifter >> 1;
                    if (bit_pos == 3'd7) begin
                        next_action();
                    end else begin
                        bit_pos = bit_pos + 3'd1;
                        ph = PH_WR_LOW;
                        slot_left = {8'h00, regs.write_low_us};
                    end
                end
            end
            PH_RD_LOW: begin
                drive = 1'b1;
                if (slot_end()) begin
                    ph = PH_RD_WAIT;
                    slot_left = {8'h00, regs.read_sample_us};
                end
            end
            PH_RD_WAIT: begin
                if (slot_end()) begin
                    shifter = {t.line_level, shifter[7:1]};
                    ph = PH_RD_REC;
                    slot_left = {8'h00, regs.read_recover_us};
                end
            end
            PH_RD_REC: begin
                if (slot_end()) begin
                    if (bit_pos == 3'd7) begin
                        if (cmd_q == CMD_TEMP && step == STEP_LOW_BYTE) temp_lo = shifter;
                        next_action();
                    end else begin
                        bit_pos = bit_pos + 3'd1;
                        ph = PH_RD_LOW;
                        slot_left = {8'h00, regs.read_low_us};
                    end
                end
            end
            default: ph = PH_IDLE;
        endcase
        if (cmd_done) cmds_finished++;
        r.drive_low = drive;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = cmd_done;
        r.presence_fail = no_presence;
        r.read_value = last_read;
        r.temperature_raw = last_temp;
    endtask

    task automatic clear_model();
        regs = '{reset_low_us: 16'd480, presence_poll_us: 16'd1000, presence_polls: 4'd5,
                 write_low_us: 8'd15, write_slot_us: 8'd60, read_low_us: 8'd1,
                 read_sample_us: 8'd10, read_recover_us: 8'd50};
        ph = PH_IDLE;
        slot_left = 16'd0;
        bit_pos = 3'd0;
        polls_seen = 4'd0;
        step = 4'd0;
        shifter = 8'h00;
        temp_lo = 8'h00;
        no_presence = 1'b0;
        cmd_q = CMD_RESET;
        data_q = 8'h00;
        last_read = 8'h00;
        last_temp = 16'h0000;
        cmd_done = 1'b0;
        due_words.delete();
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("word %0d: %s is %0h, expected %0h", word_no, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        tick_t   t;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[27:0]);
                if (due_words.size() == 0) begin
                    report_mismatch("word with nothing pending", m_tdata, 0);
                end else begin
                    want = due_words.pop_front();
                    if (got.drive_low !== want.drive_low)
                        report_mismatch("drive_low", got.drive_low, want.drive_low);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.presence_fail !== want.presence_fail)
                        report_mismatch("presence_fail", got.presence_fail,
                                        want.presence_fail);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.temperature_raw !== want.temperature_raw)
                        report_mismatch("temperature_raw", $unsigned(got.temperature_raw),
                                        $unsigned(want.temperature_raw));
                end
                word_no++;
            end
            if (s_tvalid && s_tready) begin
                t.start_req = s_tdata[0];
                t.command = s_tdata[3:1];
                t.data_byte = s_tdata[11:4];
                t.line_level = s_tdata[12];
                advance_one_tick(t, want);
                due_words.push_back(want);
            end
            // a write lands after the tick of the same edge has used the old value
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_RESET_LOW:    regs.reset_low_us = cfg_wdata;
                    CFG_POLL_US:      regs.presence_poll_us = cfg_wdata;
                    CFG_POLLS:        regs.presence_polls = cfg_wdata[3:0];
                    CFG_WRITE_LOW:    regs.write_low_us = cfg_wdata[7:0];
                    CFG_WRITE_SLOT:   regs.write_slot_us = cfg_wdata[7:0];
                    CFG_READ_LOW:     regs.read_low_us = cfg_wdata[7:0];
                    CFG_READ_SAMPLE:  regs.read_sample_us = cfg_wdata[7:0];
                    CFG_READ_RECOVER: regs.read_recover_us = cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        outstanding = due_words.size();
    end

endmodule

FILE: tb/sv/one_wire_temp_sensor_master_tb.sv
// one_wire_temp_sensor_master_tb: drives bus-tick words and register writes into the
// one-wire master and gives the verdict; checking is done by owm_checker.
// Depends on owm_pkg, owm_checker and one_wire_temp_sensor_master.
`timescale 1ns / 1ps

module one_wire_temp_sensor_master_tb;
    import owm_pkg::*;

    typedef enum logic [1:0] {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_mode_e;

    localparam cmd_t CMD_UNUSED_FIRST = 3'd5;
    localparam cmd_t CMD_UNUSED_LAST  = 3'd7;
    localparam int   RANDOM_TICKS     = 250;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    cfg_addr_t   cfg_addr;
    logic [15:0] cfg_wdata;

    int   errors;
    int   outstanding;
    int   cmds_finished;
    logic seq_busy;

    int tx_max;
    int rx_max;
    bit hold_off_req;
    int ticks_sent;
    int settings_used;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    one_wire_temp_sensor_master u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    owm_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .outstanding   (outstanding),
        .cmds_finished (cmds_finished),
        .seq_busy      (seq_busy)
    );

    function automatic logic pick_line(input line_mode_e mode);
        if (mode == LINE_HIGH) return 1'b1;
        if (mode == LINE_LOW) return 1'b0;
        return 1'($urandom_range(1, 0));
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_tick(input logic start, input cmd_t op, input logic [7:0] byte_in,
                             input logic line);
        int gap;
        gap = (tx_max > 0) ? $urandom_range(tx_max, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {3'b000, line, byte_in, op, start};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic run_cmd(input cmd_t op, input logic [7:0] byte_in, input line_mode_e mode);
        send_tick(1'b1, op, byte_in, pick_line(mode));
        if (seq_busy) ticks_sent++;
        while (seq_busy) begin
            // stray starts while busy must be ignored
            send_tick($urandom_range(7, 0) == 0, cmd_t'($urandom_range(7, 0)),
                      8'($urandom), pick_line(mode));
            ticks_sent++;
        end
    endtask

    task automatic settle_all();
        while (seq_busy) send_tick(1'b0, CMD_RESET, 8'h00, 1'($urandom_range(1, 0)));
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(negedge aclk);
    endtask

    task automatic put_reg(input cfg_addr_t a, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge aclk);
    endtask

    task automatic load_regs(input cfg_t c);
        put_reg(CFG_RESET_LOW, c.reset_low_us);
        put_reg(CFG_POLL_US, c.presence_poll_us);
        put_reg(CFG_POLLS, {12'h000, c.presence_polls});
        put_reg(CFG_WRITE_LOW, {8'h00, c.write_low_us});
        put_reg(CFG_WRITE_SLOT, {8'h00, c.write_slot_us});
        put_reg(CFG_READ_LOW, {8'h00, c.read_low_us});
        put_reg(CFG_READ_SAMPLE, {8'h00, c.read_sample_us});
        put_reg(CFG_READ_RECOVER, {8'h00, c.read_recover_us});
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    function automatic cfg_t random_regs();
        cfg_t c;
        c.reset_low_us = 16'($urandom_range(4, 0));
        c.presence_poll_us = 16'($urandom_range(3, 0));
        c.presence_polls = 4'($urandom_range(15, 0));
        c.write_low_us = 8'($urandom_range(3, 0));
        c.write_slot_us = 8'($urandom_range(4, 0));
        c.read_low_us = 8'($urandom_range(3, 0));
        c.read_sample_us = 8'($urandom_range(4, 0));
        c.read_recover_us = 8'($urandom_range(4, 0));
        return c;
    endfunction

    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = (rx_max > 0) ? $urandom_range(rx_max, 0) : 0;
            if (hold_off_req) begin
                stall = 200;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("timed out with %0d words outstanding", outstanding);
        $display("FAIL one_wire_temp_sensor_master");
        $finish;
    end

    initial begin : stimulus
        int   start_count;
        int   rounds;
        int   r;
        int   wait_cycles;
        cmd_t op;
        line_mode_e mode;

        s_tvalid = 1'b0;
        s_tdata = 16'h0000;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_RESET_LOW;
        cfg_wdata = 16'h0000;
        aresetn = 1'b0;
        hold_off_req = 1'b0;
        tx_max = 17;
        rx_max = 17;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle out of reset; unknown commands are ignored
        send_tick(1'b0, CMD_TEMP, 8'hFF, 1'b1);
        for (int k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++)
            run_cmd(cmd_t'(k), 8'hFF, LINE_RANDOM);

        // shortest slots, zero-length slots and no poll retries
        settle_all();
        load_regs('{reset_low_us: 16'd1, presence_poll_us: 16'd1, presence_polls: 4'd0,
                    write_low_us: 8'd0, write_slot_us: 8'd1, read_low_us: 8'd1,
                    read_sample_us: 8'd0, read_recover_us: 8'd1});
        run_cmd(CMD_RESET, 8'h00, LINE_HIGH);
        run_cmd(CMD_RESET, 8'h00, LINE_LOW);
        run_cmd(CMD_WRITE, 8'h00, LINE_RANDOM);
        run_cmd(CMD_WRITE, 8'hFF, LINE_RANDOM);
        run_cmd(CMD_READ, 8'h00, LINE_HIGH);
        run_cmd(CMD_READ, 8'h00, LINE_LOW);
        run_cmd(CMD_SKIP, 8'h3C, LINE_RANDOM);
        run_cmd(CMD_TEMP, 8'h00, LINE_RANDOM);

        // longer slots, back to back
        settle_all();
        tx_max = 0;
        rx_max = 0;
        load_regs('{reset_low_us: 16'd20, presence_poll_us: 16'd3, presence_polls: 4'd2,
                    write_low_us: 8'd3, write_slot_us: 8'd5, read_low_us: 8'd2,
                    read_sample_us: 8'd3, read_recover_us: 8'd4});
        run_cmd(CMD_RESET, 8'h00, LINE_HIGH);
        run_cmd(CMD_WRITE, 8'h96, LINE_RANDOM);

        // every presence retry used up
        settle_all();
        tx_max = 17;
        rx_max = 17;
        load_regs('{reset_low_us: 16'd2, presence_poll_us: 16'd1, presence_polls: 4'hF,
                    write_low_us: 8'd1, write_slot_us: 8'd2, read_low_us: 8'd2,
                    read_sample_us: 8'd1, read_recover_us: 8'd2});
        run_cmd(CMD_RESET, 8'h00, LINE_HIGH);
        run_cmd(CMD_SKIP, 8'hFF, LINE_LOW);

        start_count = ticks_sent;
        rounds = 0;
        while (rounds < 3 || ticks_sent - start_count < RANDOM_TICKS) begin
            settle_all();
            load_regs(random_regs());
            if (rounds == 0 || rounds == 2) hold_off_req = 1'b1;
            repeat (2) begin
                tx_max = ($urandom_range(3, 0) == 0) ? 0 : 17;
                rx_max = ($urandom_range(3, 0) == 0) ? 0 : 17;
                r = $urandom_range(15, 0);
                if (r < 4) op = CMD_RESET;
                else if (r < 8) op = CMD_WRITE;
                else if (r < 11) op = CMD_READ;
                else if (r < 13) op = CMD_SKIP;
                else if (r < 14) op = CMD_TEMP;
                else op = cmd_t'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                r = $urandom_range(5, 0);
                mode = (r == 0) ? LINE_HIGH : (r == 1) ? LINE_LOW : LINE_RANDOM;
                run_cmd(op, 8'($urandom), mode);
                if (rounds == 1) settle_all();
            end
            rounds++;
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(negedge aclk);
            wait_cycles++;
        end while (outstanding != 0 && wait_cycles < 5000);
        repeat (4) @(posedge aclk);

        $display("Sent %0d bus ticks; %0d commands completed over %0d register settings.",
                 ticks_sent, cmds_finished, settings_used);
        if (outstanding != 0) $display("%0d expected words never arrived", outstanding);
        if (errors == 0 && outstanding == 0) begin
            $display("PASS one_wire_temp_sensor_master");
        end else begin
            $display("FAIL one_wire_temp_sensor_master");
        end
        $finish;
    end

endmodule
